// ----- src/conv_window_gather_macros.svh -----
`ifndef CONV_WINDOW_GATHER_MACROS_SVH
`define CONV_WINDOW_GATHER_MACROS_SVH

// same-cycle implication, reset masks the check
`define CWG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define CWG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cwg_pkg.sv -----
`default_nettype none

package cwg_pkg;

    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_HEIGHT   = 32;
    localparam int DEF_MAX_WIDTH    = 32;

    localparam int PIXEL_W    = 32;
    localparam int CHANNEL_W  = 2;
    localparam int INDEX_W    = 6;
    localparam int TAP_W      = 4;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    localparam int TAP_COUNT   = 16;
    localparam int FILLER_TAPS = 7;
    localparam int K3_TAPS     = TAP_COUNT - FILLER_TAPS;
    localparam logic [2:0] KERNEL_SIDE_LARGE = 3'd4;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_WINDOW = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_CHANNELS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_SIZE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_AMOUNT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_STEP    = 3'd5;

    localparam logic [5:0] RST_IMAGE_HEIGHT   = 6'd32;
    localparam logic [5:0] RST_IMAGE_WIDTH    = 6'd32;
    localparam logic [2:0] RST_IMAGE_CHANNELS = 3'd4;
    localparam logic [2:0] RST_KERNEL_SIZE    = 3'd3;
    localparam logic [1:0] RST_PAD_AMOUNT     = 2'd1;
    localparam logic [2:0] RST_STRIDE_STEP    = 3'd1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_GATHER = 2'b10
    } state_t;

    typedef struct packed {
        logic write_pixel;
        logic load_window;
        logic issue;
    } cmd_t;

    typedef struct packed {
        logic advance;
        logic last_issue;
    } status_t;

endpackage

`default_nettype wire

// ----- src/cwg_ram.sv -----
`default_nettype none

module cwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/cwg_ctrl.sv -----
`default_nettype none

module cwg_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             in_kind,
    input  wire cwg_pkg::status_t status,
    output logic                  s_tready,
    output cwg_pkg::cmd_t         cmd
);
    import cwg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_kind == KIND_WINDOW) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                if (status.advance && status.last_issue) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready        = (state_reg == ST_IDLE);
    assign cmd.write_pixel = s_tready && s_tvalid && (in_kind == KIND_WRITE);
    assign cmd.load_window = s_tready && s_tvalid && (in_kind == KIND_WINDOW);
    assign cmd.issue       = (state_reg == ST_GATHER);

endmodule

`default_nettype wire

// ----- src/cwg_datapath.sv -----
`default_nettype none

module cwg_datapath #(
    parameter int MAX_CHANNELS = cwg_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = cwg_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = cwg_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cwg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire cwg_pkg::cmd_t                   cmd,
    input  wire logic [cwg_pkg::CHANNEL_W-1:0]   in_channel,
    input  wire logic [cwg_pkg::INDEX_W-1:0]     in_row,
    input  wire logic [cwg_pkg::INDEX_W-1:0]     in_col,
    input  wire logic [cwg_pkg::PIXEL_W-1:0]     in_pixel,
    input  wire logic                            m_tready,
    output cwg_pkg::status_t                     status,
    output logic                                 out_valid,
    output logic [cwg_pkg::PIXEL_W-1:0]          out_value,
    output logic [cwg_pkg::TAP_W-1:0]            out_tap,
    output logic                                 out_inside,
    output logic                                 out_last
);
    import cwg_pkg::*;

    localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int PLANE = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [5:0] img_h_reg;
    logic [5:0] img_w_reg;
    logic [2:0] img_ch_reg;
    logic [2:0] ksize_reg;
    logic [1:0] pad_reg;
    logic [2:0] stride_reg;

    logic [CHANNEL_W-1:0] win_ch_reg;
    logic signed [10:0]   row0_reg;
    logic signed [10:0]   col0_reg;
    logic                 ch_ok_reg;
    logic                 k4_reg;
    logic [TAP_W-1:0]     tap_reg;
    logic [1:0]           trow_reg;
    logic [1:0]           tcol_reg;

    logic                 s1_valid_reg;
    logic [TAP_W-1:0]     s1_tap_reg;
    logic                 s1_inside_reg;
    logic                 s1_last_reg;

    logic                 out_valid_reg;
    logic [PIXEL_W-1:0]   out_value_reg;
    logic [TAP_W-1:0]     out_tap_reg;
    logic                 out_inside_reg;
    logic                 out_last_reg;

    logic [5:0]           h_eff;
    logic [5:0]           w_eff;
    logic [8:0]           prod_row;
    logic [8:0]           prod_col;
    logic signed [10:0]   tap_r;
    logic signed [10:0]   tap_c;
    logic                 in_kernel;
    logic                 inside_now;
    logic                 advance;
    logic                 issue_fire;
    logic [1:0]           last_col;
    logic                 wr_ok;
    logic [31:0]          wr_addr_wide;
    logic [31:0]          rd_addr_wide;
    logic [AW-1:0]        ram_addr;
    logic [PIXEL_W-1:0]   ram_rdata;

    assign h_eff = (32'(img_h_reg) > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : img_h_reg;
    assign w_eff = (32'(img_w_reg) > MAX_WIDTH) ? 6'(MAX_WIDTH) : img_w_reg;

    assign prod_row = {3'b000, in_row} * {6'b000000, stride_reg};
    assign prod_col = {3'b000, in_col} * {6'b000000, stride_reg};

    assign tap_r = row0_reg + $signed({9'b0, trow_reg});
    assign tap_c = col0_reg + $signed({9'b0, tcol_reg});

    assign in_kernel  = k4_reg || (tap_reg < TAP_W'(K3_TAPS));
    assign inside_now = ch_ok_reg && in_kernel
                        && !tap_r[10] && (tap_r[9:0] < {4'b0000, h_eff})
                        && !tap_c[10] && (tap_c[9:0] < {4'b0000, w_eff});

    assign advance    = !out_valid_reg || m_tready;
    assign issue_fire = cmd.issue && advance;
    assign last_col   = k4_reg ? 2'd3 : 2'd2;

    assign wr_ok = (32'(in_channel) < MAX_CHANNELS) && (32'(in_row) < MAX_HEIGHT)
                   && (32'(in_col) < MAX_WIDTH);
    assign wr_addr_wide = 32'(in_channel) * 32'(PLANE) + 32'(in_row) * 32'(MAX_WIDTH)
                          + 32'(in_col);
    assign rd_addr_wide = 32'(win_ch_reg) * 32'(PLANE) + 32'(tap_r[9:0]) * 32'(MAX_WIDTH)
                          + 32'(tap_c[9:0]);
    assign ram_addr = cmd.write_pixel ? wr_addr_wide[AW-1:0] : rd_addr_wide[AW-1:0];

    cwg_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.write_pixel && wr_ok),
        .rd_en   (issue_fire && inside_now),
        .addr    (ram_addr),
        .wr_data (in_pixel),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_h_reg  <= RST_IMAGE_HEIGHT;
            img_w_reg  <= RST_IMAGE_WIDTH;
            img_ch_reg <= RST_IMAGE_CHANNELS;
            ksize_reg  <= RST_KERNEL_SIZE;
            pad_reg    <= RST_PAD_AMOUNT;
            stride_reg <= RST_STRIDE_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_HEIGHT:   img_h_reg  <= cfg_wdata[5:0];
                REG_IMAGE_WIDTH:    img_w_reg  <= cfg_wdata[5:0];
                REG_IMAGE_CHANNELS: img_ch_reg <= cfg_wdata[2:0];
                REG_KERNEL_SIZE:    ksize_reg  <= cfg_wdata[2:0];
                REG_PAD_AMOUNT:     pad_reg    <= cfg_wdata[1:0];
                REG_STRIDE_STEP:    stride_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_window) begin
            win_ch_reg <= in_channel;
            row0_reg   <= $signed({2'b00, prod_row}) - $signed({9'b0, pad_reg});
            col0_reg   <= $signed({2'b00, prod_col}) - $signed({9'b0, pad_reg});
            ch_ok_reg  <= ({1'b0, in_channel} < img_ch_reg)
                          && (32'(in_channel) < MAX_CHANNELS);
            k4_reg     <= (ksize_reg == KERNEL_SIDE_LARGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg  <= '0;
            trow_reg <= '0;
            tcol_reg <= '0;
        end else if (cmd.load_window) begin
            tap_reg  <= '0;
            trow_reg <= '0;
            tcol_reg <= '0;
        end else if (issue_fire) begin
            tap_reg <= tap_reg + TAP_W'(1);
            if (tcol_reg == last_col) begin
                tcol_reg <= '0;
                trow_reg <= trow_reg + 2'd1;
            end else begin
                tcol_reg <= tcol_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= issue_fire;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_tap_reg     <= tap_reg;
            s1_inside_reg  <= inside_now;
            s1_last_reg    <= (tap_reg == TAP_W'(TAP_COUNT - 1));
            out_value_reg  <= s1_inside_reg ? ram_rdata : '0;
            out_tap_reg    <= s1_tap_reg;
            out_inside_reg <= s1_inside_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign status.advance    = advance;
    assign status.last_issue = (tap_reg == TAP_W'(TAP_COUNT - 1));

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_tap    = out_tap_reg;
    assign out_inside = out_inside_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// ----- src/conv_window_gather.sv -----
// Pixel write request: taken one per cycle while no window gather is in progress.
// Window request: 16 taps, one per cycle from the single-port image RAM unless
// m_tready stalls the output; each tap passes the s1 stage and the output register
// before m_, and no new request is taken until the last tap has been issued.
// Reset (aresetn low, synchronous) clears control state and loads register defaults;
// the image store is not cleared and is undefined until written.
`default_nettype none

module conv_window_gather #(
    parameter int MAX_CHANNELS = cwg_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = cwg_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = cwg_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cwg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // channel, row_index, col_index, pixel_word, zero fill
    input  wire logic [cwg_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tap_value, tap_number, zero fill
    output logic [cwg_pkg::M_TDATA_W-1:0]        m_tdata,
    // inside_image
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import cwg_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic [PIXEL_W-1:0]   out_value;
    logic [TAP_W-1:0]     out_tap;

    cwg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    cwg_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .in_channel (s_tdata[1:0]),
        .in_row     (s_tdata[7:2]),
        .in_col     (s_tdata[13:8]),
        .in_pixel   (s_tdata[45:14]),
        .m_tready   (m_tready),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_tap    (out_tap),
        .out_inside (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, out_tap, out_value};

endmodule

`default_nettype wire

// ----- src/cwg_checker.sv -----
`default_nettype none
`include "conv_window_gather_macros.svh"

module cwg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `CWG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled tap changed")
    `CWG_ASSERT_NOW(a_last_is_tap15, aclk, aresetn, m_tvalid && m_tlast, m_tdata[35:32] == 4'hF, "last flag not on tap 15")
    `CWG_ASSERT_NOW(a_outside_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[31:0] == 32'h0, "outside tap not zero")
    `CWG_ASSERT_NEXT(a_window_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready, "request taken during gather")
    `CWG_ASSERT_NEXT(a_tap_order, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !m_tvalid || (m_tdata[35:32] == $past(m_tdata[35:32]) + 4'd1), "taps out of order")

endmodule

bind conv_window_gather cwg_checker u_cwg_checker (.*);

`default_nettype wire
